/* src/rleld_pkg.sv */
package rleld_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_HDR_OK  = 2'd1,
    KIND_HDR_BAD = 2'd2
  } kind_t;

  // header byte positions
  localparam logic [6:0] IDX_MFR         = 7'd0;
  localparam logic [6:0] IDX_ENC         = 7'd2;
  localparam logic [6:0] IDX_BPP         = 7'd3;
  localparam logic [6:0] IDX_COORD_FIRST = 7'd4;
  localparam logic [6:0] IDX_COORD_LAST  = 7'd11;
  localparam logic [6:0] IDX_PLANES      = 7'd65;
  localparam logic [6:0] HDR_LAST        = 7'd127;

  localparam logic [7:0] MFR_ID   = 8'd10;
  localparam logic [7:0] ENC_RLE  = 8'd1;
  localparam logic [7:0] BPP_8    = 8'd8;
  localparam logic [7:0] PLANES_1 = 8'd1;

  localparam logic [16:0] WIDE_W_MIN = 17'd296;
  localparam logic [16:0] WIDE_W_MAX = 17'd320;
  localparam logic [16:0] WIDE_H_MIN = 17'd194;
  localparam logic [16:0] WIDE_H_MAX = 17'd200;
  localparam logic [16:0] SKIN_SIZE  = 17'd32;
  localparam int          SKIN_STRIDE = 32;

  localparam logic [1:0] RUN_MARK = 2'b11;

  typedef struct packed {
    logic       cap;
    logic [6:0] idx;
    logic [7:0] data;
  } hdr_ctl_t;

  typedef struct packed {
    logic        ok;
    logic [16:0] width;
    logic [16:0] height;
  } hdr_stat_t;

endpackage

/* src/rle_image_line_decoder_top.sv */
// Run-length image decoder for 8-bit single-plane files. Bytes arrive on the
// input channel; the first 128 form the header, whose last byte yields one
// accept or reject word. After an accepted header each literal byte yields
// one pixel word and each run marker plus value byte yields up to 63 pixel
// words, cut at the end of the row, each carrying row * stride + column.
// An input byte that causes pixels first forms the row base with the single
// multiplier in S_BASE, then yields one pixel per cycle from the shared
// address adder in S_EMIT, whenever out_stall does not hold a finished word;
// the last header byte passes through S_HCHK for the size check before its
// accept or reject word is formed. The input is stalled while a byte is
// being expanded or the header is checked; a finished word may wait in the
// output register while the next byte is taken. The skin mode bit (written
// from cfg_wr_data on cfg_wr_en) selects a 32x32 canvas (stride 32) or the
// wide canvas (stride CANVAS_WIDTH); the user is to write it only while idle,
// and the block itself does not enforce this.
module rle_image_line_decoder_top #(
  parameter int CANVAS_WIDTH = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_pixel,
  output logic [15:0] out_address,
  output logic        out_last,
  output logic        out_image_done
);

  localparam int SW = $clog2(CANVAS_WIDTH + 1);
  localparam int PW = SW + 8;

  typedef enum logic [2:0] {S_IDLE, S_HCHK, S_BASE, S_EMIT} state_t;
  typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_DONE} phase_t;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [6:0]           hcount_r, hcount_nxt;
  logic                 mode_r;
  logic                 run_pend_r, run_pend_nxt;
  logic [5:0]           run_len_r, run_len_nxt;
  logic [7:0]           row_r, row_nxt;
  logic [9:0]           col_r, col_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [7:0]           value_r, value_nxt;
  logic [15:0]          rowbase_r, rowbase_nxt;
  logic [16:0]          width_r, width_nxt;
  logic [16:0]          height_r, height_nxt;

  logic                 out_valid_r, out_valid_nxt;
  rleld_pkg::kind_t     out_kind_r, out_kind_nxt;
  logic [7:0]           out_pixel_r, out_pixel_nxt;
  logic [15:0]          out_address_r, out_address_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_done_r, out_done_nxt;

  rleld_pkg::hdr_ctl_t  hdr_ctl;
  rleld_pkg::hdr_stat_t hdr_stat;

  logic                 slot_free;
  logic                 in_acc;
  phase_t               eff_phase;
  logic [6:0]           eff_idx;
  logic [SW-1:0]        stride;
  logic [PW-1:0]        prod;
  logic [10:0]          col_inc;
  logic [7:0]           row_inc;
  logic                 line_end;
  logic                 img_end;
  logic                 pix_last;

  rleld_hdr u_hdr (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (mode_r),
    .ctl   (hdr_ctl),
    .stat  (hdr_stat)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && state_r == S_IDLE;
  assign eff_phase = in_start_image ? PH_HEADER : phase_r;
  assign eff_idx   = in_start_image ? 7'd0 : hcount_r;

  assign hdr_ctl.cap  = in_acc && eff_phase == PH_HEADER;
  assign hdr_ctl.idx  = eff_idx;
  assign hdr_ctl.data = in_data_byte;

  assign stride   = mode_r ? SW'(rleld_pkg::SKIN_STRIDE) : SW'(CANVAS_WIDTH);
  assign prod     = row_r * stride;
  assign col_inc  = {1'b0, col_r} + 11'd1;
  assign row_inc  = row_r + 8'd1;
  assign line_end = 17'(col_inc) >= width_r;
  assign img_end  = line_end && 17'(row_inc) >= height_r;
  assign pix_last = cnt_r == 6'd1 || line_end;

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    hcount_nxt      = hcount_r;
    run_pend_nxt    = run_pend_r;
    run_len_nxt     = run_len_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    cnt_nxt         = cnt_r;
    value_nxt       = value_r;
    rowbase_nxt     = rowbase_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_kind_nxt    = out_kind_r;
    out_pixel_nxt   = out_pixel_r;
    out_address_nxt = out_address_r;
    out_last_nxt    = out_last_r;
    out_done_nxt    = out_done_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_start_image) begin
            phase_nxt    = PH_HEADER;
            hcount_nxt   = '0;
            run_pend_nxt = 1'b0;
            run_len_nxt  = '0;
            row_nxt      = '0;
            col_nxt      = '0;
          end
          case (eff_phase)
            PH_HEADER: begin
              if (eff_idx == rleld_pkg::HDR_LAST) begin
                hcount_nxt   = '0;
                row_nxt      = '0;
                col_nxt      = '0;
                run_pend_nxt = 1'b0;
                state_nxt    = S_HCHK;
              end else begin
                hcount_nxt = eff_idx + 7'd1;
              end
            end
            PH_DATA: begin
              if (run_pend_r) begin
                run_pend_nxt = 1'b0;
                value_nxt    = in_data_byte;
                cnt_nxt      = run_len_r;
                if (run_len_r != 6'd0) begin
                  state_nxt = S_BASE;
                end
              end else if (in_data_byte[7:6] == rleld_pkg::RUN_MARK) begin
                run_pend_nxt = 1'b1;
                run_len_nxt  = in_data_byte[5:0];
              end else begin
                value_nxt = in_data_byte;
                cnt_nxt   = 6'd1;
                state_nxt = S_BASE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_HCHK: begin
        width_nxt  = hdr_stat.width;
        height_nxt = hdr_stat.height;
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = hdr_stat.ok ? rleld_pkg::KIND_HDR_OK : rleld_pkg::KIND_HDR_BAD;
          out_pixel_nxt   = '0;
          out_address_nxt = '0;
          out_last_nxt    = 1'b1;
          out_done_nxt    = 1'b0;
          phase_nxt       = hdr_stat.ok ? PH_DATA : PH_DONE;
          state_nxt       = S_IDLE;
        end
      end
      S_BASE: begin
        rowbase_nxt = 16'(prod);
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = rleld_pkg::KIND_PIXEL;
          out_pixel_nxt   = value_r;
          out_address_nxt = rowbase_r + 16'(col_r);
          out_last_nxt    = pix_last;
          out_done_nxt    = img_end;
          if (line_end) begin
            col_nxt = '0;
            row_nxt = row_inc;
          end else begin
            col_nxt = col_inc[9:0];
          end
          if (img_end) begin
            phase_nxt = PH_DONE;
          end
          if (pix_last) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r - 6'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HEADER;
      hcount_r    <= '0;
      mode_r      <= 1'b0;
      run_pend_r  <= 1'b0;
      run_len_r   <= '0;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      width_r     <= '0;
      height_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hcount_r    <= hcount_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      run_pend_r  <= run_pend_nxt;
      run_len_r   <= run_len_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r       <= value_nxt;
    rowbase_r     <= rowbase_nxt;
    out_kind_r    <= out_kind_nxt;
    out_pixel_r   <= out_pixel_nxt;
    out_address_r <= out_address_nxt;
    out_last_r    <= out_last_nxt;
    out_done_r    <= out_done_nxt;
  end

  assign in_stall       = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_pixel      = out_pixel_r;
  assign out_address    = out_address_r;
  assign out_last       = out_last_r;
  assign out_image_done = out_done_r;

`ifndef SYNTHESIS
  a_hdr_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != rleld_pkg::KIND_PIXEL |-> out_last_r)
    else $error("header word without last");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("image done without last");

  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> 17'(col_r) < width_r)
    else $error("column beyond image width");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT || state_r == S_BASE |-> cnt_r != 6'd0)
    else $error("expanding with zero count");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && slot_free && pix_last |=> state_r == S_IDLE && out_last_r)
    else $error("final pixel did not end expansion");
`endif

endmodule

/* src/rleld_hdr.sv */
module rleld_hdr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mode,
  input  rleld_pkg::hdr_ctl_t ctl,
  output rleld_pkg::hdr_stat_t stat
);

  logic [7:0]  hb_r    [4];
  logic [15:0] coord_r [4];
  logic [6:0]  off;
  logic [1:0]  k;
  logic        fields_ok;
  logic        size_ok;

  assign off = ctl.idx - rleld_pkg::IDX_COORD_FIRST;
  assign k   = off[2:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        hb_r[i]    <= '0;
        coord_r[i] <= '0;
      end
    end else if (ctl.cap) begin
      if (ctl.idx == rleld_pkg::IDX_MFR) begin
        hb_r[0] <= ctl.data;
      end else if (ctl.idx == rleld_pkg::IDX_ENC) begin
        hb_r[1] <= ctl.data;
      end else if (ctl.idx == rleld_pkg::IDX_BPP) begin
        hb_r[2] <= ctl.data;
      end else if (ctl.idx == rleld_pkg::IDX_PLANES) begin
        hb_r[3] <= ctl.data;
      end else if (ctl.idx >= rleld_pkg::IDX_COORD_FIRST &&
                   ctl.idx <= rleld_pkg::IDX_COORD_LAST) begin
        if (!ctl.idx[0]) begin
          coord_r[k][7:0] <= ctl.data;
        end else begin
          coord_r[k][15:8] <= ctl.data;
        end
      end
    end
  end

  // sizes wrap in 17 bits so inverted corners fail the range check
  assign stat.width  = {1'b0, coord_r[2]} - {1'b0, coord_r[0]} + 17'd1;
  assign stat.height = {1'b0, coord_r[3]} - {1'b0, coord_r[1]} + 17'd1;

  assign fields_ok = hb_r[0] == rleld_pkg::MFR_ID && hb_r[1] == rleld_pkg::ENC_RLE &&
                     hb_r[2] == rleld_pkg::BPP_8 && hb_r[3] == rleld_pkg::PLANES_1;

  always_comb begin
    if (mode) begin
      size_ok = stat.width == rleld_pkg::SKIN_SIZE && stat.height == rleld_pkg::SKIN_SIZE;
    end else begin
      size_ok = stat.width >= rleld_pkg::WIDE_W_MIN && stat.width <= rleld_pkg::WIDE_W_MAX &&
                stat.height >= rleld_pkg::WIDE_H_MIN && stat.height <= rleld_pkg::WIDE_H_MAX;
    end
  end

  assign stat.ok = fields_ok && size_ok;

endmodule

/* bench/tb_rle_image_line_decoder_top.sv */
`timescale 1ns / 100ps

module tb_rle_image_line_decoder_top;

  localparam int CANVAS_W = 320;
  localparam int RAND_ITEMS = 410;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE = 8;
  localparam int CYCLE_LIMIT = 10000000;

  typedef enum logic [1:0] {
    DEC_HEADER,
    DEC_DATA,
    DEC_DONE
  } dec_phase_t;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_HEADER,
    ROW_MODE
  } row_op_t;

  typedef enum logic [2:0] {
    FLAW_NONE,
    FLAW_MFR,
    FLAW_ENC,
    FLAW_BPP,
    FLAW_PLANES,
    FLAW_INVERT
  } flaw_t;

  typedef struct packed {
    rleld_pkg::kind_t kind;
    logic [7:0]       pixel;
    logic [15:0]      address;
    logic             last;
    logic             done;
  } out_word_t;

  typedef struct packed {
    row_op_t     op;
    logic        st;
    logic [7:0]  b;
    logic [15:0] x0;
    logic [15:0] y0;
    int          w;
    int          h;
    flaw_t       flaw;
    logic        typed;
    out_word_t   word;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_start_image;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_pixel;
  logic [15:0] out_address;
  logic        out_last;
  logic        out_image_done;

  // decoder shadow state
  logic        cfg_skin = 1'b0;
  dec_phase_t  dec_phase = DEC_HEADER;
  logic [6:0]  hdr_cnt = '0;
  logic [7:0]  hb_mfr = '0;
  logic [7:0]  hb_enc = '0;
  logic [7:0]  hb_bpp = '0;
  logic [7:0]  hb_planes = '0;
  logic [15:0] corner [4] = '{default: '0};
  logic [16:0] img_w = '0;
  logic [16:0] img_h = '0;
  logic [7:0]  dec_row = '0;
  logic [9:0]  dec_col = '0;
  logic        run_pend = 1'b0;
  logic [5:0]  run_len = '0;

  out_word_t   fresh [$];
  out_word_t   pending_words [$];
  out_word_t   seen_word;
  stim_row_t   plan [$];

  int          errors = 0;
  int          words_checked = 0;
  int          live_bytes = 0;
  int          ignored_bytes = 0;
  int          hdr_accepts = 0;
  int          hdr_rejects = 0;
  int          images_done = 0;
  int          cycle_count = 0;
  int          quiet_mark = 0;
  bit          gaps_on = 1'b0;
  bit          stall_on = 1'b0;
  bit          hold_req = 1'b0;
  bit          held = 1'b0;
  bit          drained_mid = 1'b0;

  rle_image_line_decoder_top #(
    .CANVAS_WIDTH(CANVAS_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_start_image (in_start_image),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_pixel      (out_pixel),
    .out_address    (out_address),
    .out_last       (out_last),
    .out_image_done (out_image_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic header_fits();
    img_w = corner[2] - corner[0] + 17'd1;
    img_h = corner[3] - corner[1] + 17'd1;
    if (hb_mfr != rleld_pkg::MFR_ID || hb_enc != rleld_pkg::ENC_RLE ||
        hb_bpp != rleld_pkg::BPP_8 || hb_planes != rleld_pkg::PLANES_1)
      return 1'b0;
    if (cfg_skin)
      return img_w == rleld_pkg::SKIN_SIZE && img_h == rleld_pkg::SKIN_SIZE;
    return img_w >= rleld_pkg::WIDE_W_MIN && img_w <= rleld_pkg::WIDE_W_MAX &&
           img_h >= rleld_pkg::WIDE_H_MIN && img_h <= rleld_pkg::WIDE_H_MAX;
  endfunction

  function automatic void expand_run(input logic [7:0] value, input int unsigned n);
    int unsigned remaining;
    int unsigned stride;
    int unsigned addr;
    logic        done;
    remaining = img_w - dec_col;
    stride = cfg_skin ? rleld_pkg::SKIN_STRIDE : CANVAS_W;
    if (n > remaining) n = remaining;
    for (int unsigned k = 0; k < n; k++) begin
      addr = dec_row * stride + dec_col;
      done = 1'b0;
      dec_col = dec_col + 10'd1;
      if (dec_col >= img_w) begin
        dec_col = '0;
        dec_row = dec_row + 8'd1;
        if (dec_row >= img_h) begin
          done = 1'b1;
          dec_phase = DEC_DONE;
        end
      end
      fresh.push_back('{rleld_pkg::KIND_PIXEL, value, addr[15:0], (k + 1 == n) || done,
                        done});
      if (done) break;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic st);
    logic [6:0] idx;
    int         k;
    if (st) begin
      dec_phase = DEC_HEADER;
      hdr_cnt = '0;
      run_pend = 1'b0;
      run_len = '0;
      dec_row = '0;
      dec_col = '0;
    end
    case (dec_phase)
      DEC_HEADER: begin
        idx = hdr_cnt;
        if (idx == rleld_pkg::IDX_MFR) hb_mfr = b;
        else if (idx == rleld_pkg::IDX_ENC) hb_enc = b;
        else if (idx == rleld_pkg::IDX_BPP) hb_bpp = b;
        else if (idx == rleld_pkg::IDX_PLANES) hb_planes = b;
        else if (idx >= rleld_pkg::IDX_COORD_FIRST && idx <= rleld_pkg::IDX_COORD_LAST) begin
          k = (idx - rleld_pkg::IDX_COORD_FIRST) >> 1;
          if (!idx[0]) corner[k][7:0] = b;
          else corner[k][15:8] = b;
        end
        if (idx == rleld_pkg::HDR_LAST) begin
          hdr_cnt = '0;
          dec_row = '0;
          dec_col = '0;
          run_pend = 1'b0;
          if (header_fits()) begin
            dec_phase = DEC_DATA;
            fresh.push_back('{rleld_pkg::KIND_HDR_OK, 8'd0, 16'd0, 1'b1, 1'b0});
          end else begin
            dec_phase = DEC_DONE;
            fresh.push_back('{rleld_pkg::KIND_HDR_BAD, 8'd0, 16'd0, 1'b1, 1'b0});
          end
        end else begin
          hdr_cnt = idx + 7'd1;
        end
      end
      DEC_DATA: begin
        if (run_pend) begin
          run_pend = 1'b0;
          expand_run(b, run_len);
        end else if (b[7:6] == rleld_pkg::RUN_MARK) begin
          run_pend = 1'b1;
          run_len = b[5:0];
        end else begin
          expand_run(b, 1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
                           input out_word_t tw);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_image <= st;
    do @(posedge clk); while (in_stall);
    if (dec_phase == DEC_DONE && !st) ignored_bytes++;
    else live_bytes++;
    decode_byte(b, st);
    if (typed) begin
      pending_words.push_back(tw);
    end else begin
      foreach (fresh[i]) pending_words.push_back(fresh[i]);
    end
    fresh.delete();
    if (quiet_mark != 0 && live_bytes >= quiet_mark) begin
      gaps_on = 1'b0;
      stall_on = 1'b0;
    end
  endtask

  task automatic send_header(input logic [7:0] mfr, input logic [7:0] enc,
                             input logic [7:0] bpp, input logic [7:0] planes,
                             input logic [15:0] xmin, input logic [15:0] ymin,
                             input logic [15:0] xmax, input logic [15:0] ymax,
                             input logic st, input logic typed,
                             input rleld_pkg::kind_t verdict);
    logic [7:0]  hb [128];
    logic [15:0] c [4];
    c = '{xmin, ymin, xmax, ymax};
    for (int i = 0; i < 128; i++) hb[i] = 8'($urandom);
    hb[rleld_pkg::IDX_MFR] = mfr;
    hb[rleld_pkg::IDX_ENC] = enc;
    hb[rleld_pkg::IDX_BPP] = bpp;
    hb[rleld_pkg::IDX_PLANES] = planes;
    for (int j = 0; j < 4; j++) begin
      hb[rleld_pkg::IDX_COORD_FIRST + 2 * j] = c[j][7:0];
      hb[rleld_pkg::IDX_COORD_FIRST + 2 * j + 1] = c[j][15:8];
    end
    for (int i = 0; i < 128; i++)
      send_byte(hb[i], st && i == 0, typed && i == rleld_pkg::HDR_LAST,
                '{verdict, 8'd0, 16'd0, 1'b1, 1'b0});
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic v);
    wait_drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_skin = v;
  endtask

  task automatic random_image(input int nth);
    int          w;
    int          h;
    int          n_data;
    int          flavor;
    int          pick;
    int          len;
    int          k;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] tmp;
    logic [7:0]  mfr;
    logic [7:0]  enc;
    logic [7:0]  bpp;
    logic [7:0]  planes;
    w = cfg_skin ? 32 : $urandom_range(296, 320);
    h = cfg_skin ? 32 : $urandom_range(194, 200);
    x0 = 16'($urandom_range(0, 1000));
    y0 = 16'($urandom_range(0, 1000));
    mfr = rleld_pkg::MFR_ID;
    enc = rleld_pkg::ENC_RLE;
    bpp = rleld_pkg::BPP_8;
    planes = rleld_pkg::PLANES_1;
    flavor = (nth == 0) ? 11 : $urandom_range(0, 13);
    case (flavor)
      0: begin
        // restart partway through the header
        n_data = $urandom_range(1, 126);
        for (k = 0; k < n_data; k++) send_byte(8'($urandom), k == 0, 1'b0, '0);
        return;
      end
      1: mfr = 8'($urandom);
      2: enc = 8'($urandom);
      3: bpp = 8'($urandom);
      4: planes = 8'($urandom);
      5: begin
        if (cfg_skin) begin
          w = $urandom_range(31, 33);
          h = $urandom_range(31, 33);
        end else begin
          w = $urandom_range(290, 326);
          h = $urandom_range(190, 204);
        end
      end
      6: begin
        x0 = 16'($urandom);
        y0 = 16'($urandom);
      end
      default: ;
    endcase
    x1 = 16'(x0 + w - 1);
    y1 = 16'(y0 + h - 1);
    if (flavor == 7) begin
      tmp = x0;
      x0 = x1;
      x1 = tmp;
    end
    send_header(mfr, enc, bpp, planes, x0, y0, x1, y1, 1'b1, 1'b0,
                rleld_pkg::KIND_HDR_OK);
    if (dec_phase == DEC_DATA && !held) begin
      hold_req = 1'b1;
      held = 1'b1;
    end
    if (cfg_skin) n_data = (nth == 0 || $urandom_range(0, 2) != 0) ? 400 : $urandom_range(20, 100);
    else n_data = $urandom_range(10, 80);
    k = 0;
    while (k < n_data && dec_phase == DEC_DATA) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        len = (pick == 0) ? 0 : (cfg_skin ? $urandom_range(16, 63) : $urandom_range(1, 63));
        send_byte({rleld_pkg::RUN_MARK, 6'(len)}, 1'b0, 1'b0, '0);
        send_byte(8'($urandom), 1'b0, 1'b0, '0);
        k += 2;
      end else if (pick < 19) begin
        send_byte(8'($urandom_range(0, 8'hBF)), 1'b0, 1'b0, '0);
        k++;
      end else begin
        send_byte(8'($urandom), 1'b0, 1'b0, '0);
        k++;
      end
      if (!drained_mid && k >= 8) begin
        wait_drain();
        drained_mid = 1'b1;
      end
    end
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
  endtask

  function automatic stim_row_t hdr_row(input logic st, input logic [15:0] x0,
                                        input logic [15:0] y0, input int w, input int h,
                                        input flaw_t flaw, input rleld_pkg::kind_t verdict);
    stim_row_t r;
    r = '0;
    r.op = ROW_HEADER;
    r.st = st;
    r.x0 = x0;
    r.y0 = y0;
    r.w = w;
    r.h = h;
    r.flaw = flaw;
    r.typed = 1'b1;
    r.word = '{verdict, 8'd0, 16'd0, 1'b1, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.op = ROW_BYTE;
    r.b = b;
    return r;
  endfunction

  function automatic stim_row_t mode_row(input logic v);
    stim_row_t r;
    r = '0;
    r.op = ROW_MODE;
    r.b = {7'd0, v};
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        if (errors < 10)
          $display("unexpected word: kind %0d pixel %0d address %0d last %0b done %0b",
                   out_kind, out_pixel, out_address, out_last, out_image_done);
        errors++;
      end else begin
        seen_word = pending_words.pop_front();
        words_checked++;
        if (seen_word.kind == rleld_pkg::KIND_HDR_OK) hdr_accepts++;
        if (seen_word.kind == rleld_pkg::KIND_HDR_BAD) hdr_rejects++;
        if (seen_word.done) images_done++;
        if (out_kind !== seen_word.kind || out_pixel !== seen_word.pixel ||
            out_address !== seen_word.address || out_last !== seen_word.last ||
            out_image_done !== seen_word.done) begin
          if (errors < 10)
            $display("word %0d mismatch: exp kind %0d pix %0d addr %0d last %0b done %0b, %s",
                     words_checked, seen_word.kind, seen_word.pixel, seen_word.address,
                     seen_word.last, seen_word.done,
                     $sformatf("got kind %0d pix %0d addr %0d last %0b done %0b",
                               out_kind, out_pixel, out_address, out_last, out_image_done));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    stim_row_t   r;
    logic [15:0] xmin;
    logic [15:0] ymin;
    logic [15:0] xmax;
    logic [15:0] ymax;
    int          nth;
    int          rand_base;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'd0;
    in_start_image = 1'b0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // header taken without a start after reset
    plan.push_back(hdr_row(1'b0, 16'd0, 16'd0, 320, 200, FLAW_NONE, rleld_pkg::KIND_HDR_OK));
    r = byte_row(8'h00);
    r.typed = 1'b1;
    r.word = '{rleld_pkg::KIND_PIXEL, 8'h00, 16'd0, 1'b1, 1'b0};
    plan.push_back(r);
    plan.push_back(byte_row(8'hBF));
    // zero-length run
    plan.push_back(byte_row(8'hC0));
    plan.push_back(byte_row(8'hFF));
    plan.push_back(byte_row(8'hFF));
    plan.push_back(byte_row(8'hAA));
    plan.push_back(hdr_row(1'b1, 16'd7, 16'd3, 296, 194, FLAW_NONE, rleld_pkg::KIND_HDR_OK));
    plan.push_back(byte_row(8'hC5));
    plan.push_back(byte_row(8'h80));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 295, 200, FLAW_NONE, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 321, 200, FLAW_NONE, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 320, 193, FLAW_NONE, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 320, 201, FLAW_NONE, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(mode_row(1'b1));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 32, 31, FLAW_NONE, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 32, 32, FLAW_MFR, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 32, 32, FLAW_ENC, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 32, 32, FLAW_BPP, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd0, 16'd0, 32, 32, FLAW_PLANES, rleld_pkg::KIND_HDR_BAD));
    plan.push_back(hdr_row(1'b1, 16'd40, 16'd9, 32, 32, FLAW_INVERT, rleld_pkg::KIND_HDR_BAD));
    // ignored after a reject
    plan.push_back(byte_row(8'h55));
    plan.push_back(hdr_row(1'b1, 16'hFFE0, 16'hFFE0, 32, 32, FLAW_NONE,
                           rleld_pkg::KIND_HDR_OK));
    // run cut at the row end
    plan.push_back(byte_row(8'hFF));
    plan.push_back(byte_row(8'h7E));
    // stride change in the middle of an image
    plan.push_back(mode_row(1'b0));
    plan.push_back(byte_row(8'h12));

    foreach (plan[i]) begin
      case (plan[i].op)
        ROW_MODE: begin
          set_mode(plan[i].b[0]);
        end
        ROW_BYTE: begin
          send_byte(plan[i].b, plan[i].st, plan[i].typed, plan[i].word);
        end
        default: begin
          xmin = plan[i].x0;
          ymin = plan[i].y0;
          xmax = 16'(plan[i].x0 + plan[i].w - 1);
          ymax = 16'(plan[i].y0 + plan[i].h - 1);
          if (plan[i].flaw == FLAW_INVERT) begin
            xmin = xmax;
            xmax = plan[i].x0;
          end
          send_header(plan[i].flaw == FLAW_MFR ? rleld_pkg::MFR_ID ^ 8'h01
                                               : rleld_pkg::MFR_ID,
                      plan[i].flaw == FLAW_ENC ? rleld_pkg::ENC_RLE ^ 8'h01
                                               : rleld_pkg::ENC_RLE,
                      plan[i].flaw == FLAW_BPP ? rleld_pkg::BPP_8 ^ 8'h01
                                               : rleld_pkg::BPP_8,
                      plan[i].flaw == FLAW_PLANES ? rleld_pkg::PLANES_1 ^ 8'h01
                                                  : rleld_pkg::PLANES_1,
                      xmin, ymin, xmax, ymax, plan[i].st, plan[i].typed,
                      plan[i].word.kind);
        end
      endcase
    end

    rand_base = live_bytes;
    quiet_mark = rand_base + RAND_ITEMS * 3 / 4;
    set_mode(1'b1);
    nth = 0;
    while (live_bytes - rand_base < RAND_ITEMS) begin
      if (nth != 0 && $urandom_range(0, 2) != 0) set_mode($urandom_range(0, 2) != 0);
      random_image(nth);
      nth++;
    end

    wait_drain();
    repeat (4 * SETTLE) @(posedge clk);
    $display("covered %0d decoded bytes and %0d ignored bytes over %0d random images",
             live_bytes, ignored_bytes, nth);
    $display("checked %0d words: %0d headers accepted, %0d rejected, %0d images completed",
             words_checked, hdr_accepts, hdr_rejects, images_done);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rleld_pkg.sv
src/rleld_hdr.sv
src/rle_image_line_decoder_top.sv
bench/tb_rle_image_line_decoder_top.sv
